FILE: design/dhfk_pkg.sv
// shared constants and arithmetic helpers for the dh forward kinematics core
`timescale 1ns / 1ps
package dhfk_pkg;

   localparam int JOINT_COUNT   = 6;
   localparam int FRACTION_BITS = 16;
   localparam int GUARD_BITS    = 12;
   localparam int ANGLE_W       = 16;
   localparam int LEN_W         = 18;
   localparam int COORD_W       = 20;
   localparam int TRIG_W        = 32;
   localparam int UQ_W          = 31;
   localparam int POS_W         = 38;
   localparam int PROD_W        = 64;
   localparam int DPROD_W       = 50;
   localparam int SUM_W         = 66;
   localparam int Q_BITS        = 30;
   localparam int SINE_LATENCY  = 8;
   localparam int ITEM_COUNT    = 10;
   localparam int POS_ITEMS     = JOINT_COUNT + 1;
   localparam int CNT_W         = 4;
   localparam int CSR_IDX_W     = 3;

   // quarter and half turn as binary angles
   localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;
   localparam logic [ANGLE_W-1:0] HALF_TURN    = 16'd32768;

   localparam logic signed [TRIG_W-1:0] ONE_Q30 = 32'sd1073741824;

   // odd taylor coefficients, highest order first
   localparam logic [UQ_W-1:0] SIN_COEF [0:5] = '{
      31'd3864, 31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
   };

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_LINK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_LINK = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FOREARM     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLANGE      = 3'd4;

   // result kinds
   localparam logic KIND_JOINT = 1'b0;
   localparam logic KIND_AXIS  = 1'b1;

   // sine of the link twist of each joint
   function automatic int twist_sin(input int k);
      int r;
      case (k)
         0:       r = -1;
         2, 3, 4: r = 1;
         default: r = 0;
      endcase
      return r;
   endfunction

   // unsigned q30 multiply, rounded half up
   function automatic logic [UQ_W-1:0] umul30(input logic [UQ_W-1:0] a,
                                              input logic [UQ_W-1:0] b);
      logic [2*UQ_W-1:0] m;
      m = {{UQ_W{1'b0}}, a} * {{UQ_W{1'b0}}, b} + (62'd1 << (Q_BITS - 1));
      return m[Q_BITS+UQ_W-1:Q_BITS];
   endfunction

   // arithmetic right shift rounding half away from zero
   function automatic logic signed [SUM_W-1:0] round_away(input logic signed [SUM_W-1:0] v,
                                                          input int unsigned s);
      logic signed [SUM_W-1:0] half;
      half = 66'sd1 <<< (s - 1);
      return (v + half - $signed({{(SUM_W-1){1'b0}}, v[SUM_W-1]})) >>> s;
   endfunction

   // clamp to the coordinate field range
   function automatic logic [COORD_W-1:0] saturate(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      logic [COORD_W-1:0] r;
      hi = (66'sd1 <<< (COORD_W - 1)) - 66'sd1;
      lo = -(66'sd1 <<< (COORD_W - 1));
      if (v > hi) begin
         r = hi[COORD_W-1:0];
      end else if (v < lo) begin
         r = lo[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: design/dhfk_sine.sv
// pipelined q30 sine of a binary angle, quarter-wave horner evaluation
`timescale 1ns / 1ps
module dhfk_sine (
   input  logic                                     clock,
   input  logic [dhfk_pkg::ANGLE_W-1:0]             angle,
   output logic signed [dhfk_pkg::TRIG_W-1:0]       sine
);

   logic [14:0]                       r_eff;
   logic [dhfk_pkg::UQ_W-1:0]         u_in;
   logic [dhfk_pkg::UQ_W-1:0]         u_ff   [0:6];
   logic                              neg_ff [0:6];
   logic                              one_ff [0:6];
   logic [dhfk_pkg::UQ_W-1:0]         u2_ff  [1:5];
   logic [dhfk_pkg::UQ_W-1:0]         p_ff   [2:6];
   logic [dhfk_pkg::UQ_W-1:0]         v;
   logic signed [dhfk_pkg::TRIG_W-1:0] sine_in;
   logic signed [dhfk_pkg::TRIG_W-1:0] sine_ff;

   // fold into the first quadrant
   always_comb begin
      r_eff = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
      u_in  = {r_eff, 16'b0};
   end

   // last multiply and sign
   always_comb begin
      v = one_ff[6] ? dhfk_pkg::ONE_Q30[dhfk_pkg::UQ_W-1:0]
                    : dhfk_pkg::umul30(p_ff[6], u_ff[6]);
      sine_in = neg_ff[6] ? -$signed({1'b0, v}) : $signed({1'b0, v});
   end

   // horner stages, one multiply each
   always_ff @(posedge clock) begin
      u_ff[0]   <= u_in;
      neg_ff[0] <= angle[15];
      one_ff[0] <= r_eff[14];
      for (int s = 1; s <= 6; s++) begin
         u_ff[s]   <= u_ff[s-1];
         neg_ff[s] <= neg_ff[s-1];
         one_ff[s] <= one_ff[s-1];
      end
      u2_ff[1] <= dhfk_pkg::umul30(u_ff[0], u_ff[0]);
      for (int s = 2; s <= 5; s++) begin
         u2_ff[s] <= u2_ff[s-1];
      end
      p_ff[2] <= dhfk_pkg::SIN_COEF[1] - dhfk_pkg::umul30(dhfk_pkg::SIN_COEF[0], u2_ff[1]);
      for (int s = 3; s <= 6; s++) begin
         p_ff[s] <= dhfk_pkg::SIN_COEF[s-1] - dhfk_pkg::umul30(p_ff[s-1], u2_ff[s-1]);
      end
      sine_ff <= sine_in;
   end

   assign sine = sine_ff;

endmodule

FILE: design/dhfk_joint.sv
// one dh transform stage: rotation and position update over two register stages
`timescale 1ns / 1ps
module dhfk_joint #(
   parameter int JOINT_INDEX = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [dhfk_pkg::LEN_W-1:0]     link_offset,
   input  logic signed [dhfk_pkg::TRIG_W-1:0]    ct_in  [0:5],
   input  logic signed [dhfk_pkg::TRIG_W-1:0]    st_in  [0:5],
   input  logic signed [dhfk_pkg::TRIG_W-1:0]    t0_in  [0:5],
   input  logic signed [dhfk_pkg::TRIG_W-1:0]    t1_in  [0:5],
   input  logic signed [dhfk_pkg::TRIG_W-1:0]    rot_in [0:2][0:2],
   input  logic signed [dhfk_pkg::POS_W-1:0]     pos_in [0:6][0:2],
   output logic                                  out_valid,
   output logic signed [dhfk_pkg::TRIG_W-1:0]    ct_out  [0:5],
   output logic signed [dhfk_pkg::TRIG_W-1:0]    st_out  [0:5],
   output logic signed [dhfk_pkg::TRIG_W-1:0]    t0_out  [0:5],
   output logic signed [dhfk_pkg::TRIG_W-1:0]    t1_out  [0:5],
   output logic signed [dhfk_pkg::TRIG_W-1:0]    rot_out [0:2][0:2],
   output logic signed [dhfk_pkg::POS_W-1:0]     pos_out [0:6][0:2]
);

   localparam int TWIST = dhfk_pkg::twist_sin(JOINT_INDEX);

   logic                                 v1_ff;
   logic signed [dhfk_pkg::PROD_W-1:0]   m0c_ff [0:2];
   logic signed [dhfk_pkg::PROD_W-1:0]   m1s_ff [0:2];
   logic signed [dhfk_pkg::PROD_W-1:0]   m0s_ff [0:2];
   logic signed [dhfk_pkg::PROD_W-1:0]   m1c_ff [0:2];
   logic signed [dhfk_pkg::PROD_W-1:0]   q0_ff  [0:2];
   logic signed [dhfk_pkg::PROD_W-1:0]   q1_ff  [0:2];
   logic signed [dhfk_pkg::DPROD_W-1:0]  q2_ff  [0:2];
   logic signed [dhfk_pkg::TRIG_W-1:0]   r2_ff  [0:2];
   logic signed [dhfk_pkg::TRIG_W-1:0]   ct1_ff [0:5];
   logic signed [dhfk_pkg::TRIG_W-1:0]   st1_ff [0:5];
   logic signed [dhfk_pkg::TRIG_W-1:0]   t01_ff [0:5];
   logic signed [dhfk_pkg::TRIG_W-1:0]   t11_ff [0:5];
   logic signed [dhfk_pkg::POS_W-1:0]    pos1_ff [0:6][0:2];

   logic                                 v2_ff;
   logic signed [dhfk_pkg::TRIG_W-1:0]   rot_in2 [0:2][0:2];
   logic signed [dhfk_pkg::POS_W-1:0]    pos_in2 [0:6][0:2];
   logic signed [dhfk_pkg::TRIG_W-1:0]   rot_ff  [0:2][0:2];
   logic signed [dhfk_pkg::POS_W-1:0]    pos_ff  [0:6][0:2];
   logic signed [dhfk_pkg::TRIG_W-1:0]   ct2_ff [0:5];
   logic signed [dhfk_pkg::TRIG_W-1:0]   st2_ff [0:5];
   logic signed [dhfk_pkg::TRIG_W-1:0]   t02_ff [0:5];
   logic signed [dhfk_pkg::TRIG_W-1:0]   t12_ff [0:5];

   // stage one: products of the incoming rotation rows
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         m0c_ff[i] <= rot_in[i][0] * ct_in[JOINT_INDEX];
         m1s_ff[i] <= rot_in[i][1] * st_in[JOINT_INDEX];
         m0s_ff[i] <= rot_in[i][0] * st_in[JOINT_INDEX];
         m1c_ff[i] <= rot_in[i][1] * ct_in[JOINT_INDEX];
         q0_ff[i]  <= rot_in[i][0] * t0_in[JOINT_INDEX];
         q1_ff[i]  <= rot_in[i][1] * t1_in[JOINT_INDEX];
         q2_ff[i]  <= rot_in[i][2] * link_offset;
         r2_ff[i]  <= rot_in[i][2];
      end
      ct1_ff  <= ct_in;
      st1_ff  <= st_in;
      t01_ff  <= t0_in;
      t11_ff  <= t1_in;
      pos1_ff <= pos_in;
   end

   // stage two: sums, rounding and twist selection
   always_comb begin
      logic signed [dhfk_pkg::SUM_W-1:0] s0;
      logic signed [dhfk_pkg::SUM_W-1:0] sd;
      logic signed [dhfk_pkg::SUM_W-1:0] sp;
      logic signed [dhfk_pkg::TRIG_W-1:0] d;
      pos_in2 = pos1_ff;
      for (int i = 0; i < 3; i++) begin
         s0 = dhfk_pkg::round_away(dhfk_pkg::SUM_W'(m0c_ff[i]) + dhfk_pkg::SUM_W'(m1s_ff[i]),
                                   dhfk_pkg::Q_BITS);
         sd = dhfk_pkg::round_away(dhfk_pkg::SUM_W'(m1c_ff[i]) - dhfk_pkg::SUM_W'(m0s_ff[i]),
                                   dhfk_pkg::Q_BITS);
         sp = dhfk_pkg::round_away(dhfk_pkg::SUM_W'(q0_ff[i]) + dhfk_pkg::SUM_W'(q1_ff[i])
                                   + (dhfk_pkg::SUM_W'(q2_ff[i]) <<< dhfk_pkg::GUARD_BITS),
                                   dhfk_pkg::Q_BITS);
         d = sd[dhfk_pkg::TRIG_W-1:0];
         rot_in2[i][0] = s0[dhfk_pkg::TRIG_W-1:0];
         if (TWIST == 0) begin
            rot_in2[i][1] = d;
            rot_in2[i][2] = r2_ff[i];
         end else if (TWIST > 0) begin
            rot_in2[i][1] = r2_ff[i];
            rot_in2[i][2] = -d;
         end else begin
            rot_in2[i][1] = -r2_ff[i];
            rot_in2[i][2] = d;
         end
         pos_in2[JOINT_INDEX+1][i] = pos1_ff[JOINT_INDEX][i] + sp[dhfk_pkg::POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rot_ff <= rot_in2;
      pos_ff <= pos_in2;
      ct2_ff <= ct1_ff;
      st2_ff <= st1_ff;
      t02_ff <= t01_ff;
      t12_ff <= t11_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign rot_out   = rot_ff;
   assign pos_out   = pos_ff;
   assign ct_out    = ct2_ff;
   assign st_out    = st2_ff;
   assign t0_out    = t02_ff;
   assign t1_out    = t12_ff;

endmodule

FILE: design/dhfk_out.sv
// result bank and serializer: ten items per pose, one per cycle
`timescale 1ns / 1ps
module dhfk_out #(
   parameter int FRACTION_BITS = dhfk_pkg::FRACTION_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic signed [dhfk_pkg::POS_W-1:0]    pos_in [0:6][0:2],
   input  logic signed [dhfk_pkg::TRIG_W-1:0]   rot_in [0:2][0:2],
   output logic                                 rsp_valid,
   output logic                                 rsp_item_kind,
   output logic [2:0]                           rsp_item_index,
   output logic signed [dhfk_pkg::COORD_W-1:0]  rsp_coord_x,
   output logic signed [dhfk_pkg::COORD_W-1:0]  rsp_coord_y,
   output logic signed [dhfk_pkg::COORD_W-1:0]  rsp_coord_z,
   output logic                                 rsp_last_item
);

   localparam logic [dhfk_pkg::CNT_W-1:0] LAST_CNT = dhfk_pkg::CNT_W'(dhfk_pkg::ITEM_COUNT - 1);
   localparam logic [dhfk_pkg::CNT_W-1:0] AXIS_CNT = dhfk_pkg::CNT_W'(dhfk_pkg::POS_ITEMS);

   logic signed [dhfk_pkg::POS_W-1:0]   pos_bank_ff [0:6][0:2];
   logic signed [dhfk_pkg::TRIG_W-1:0]  rot_bank_ff [0:2][0:2];
   logic                                active_ff, active_in;
   logic [dhfk_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic                                rsp_valid_ff;
   logic                                kind_ff, kind_in;
   logic [2:0]                          index_ff, index_in;
   logic [dhfk_pkg::COORD_W-1:0]        coord_ff [0:2];
   logic [dhfk_pkg::COORD_W-1:0]        coord_in [0:2];
   logic                                last_ff;

   // bank load
   always_ff @(posedge clock) begin
      if (in_valid) begin
         pos_bank_ff <= pos_in;
         rot_bank_ff <= rot_in;
      end
   end

   // select, round and clamp the current item
   always_comb begin
      logic [dhfk_pkg::CNT_W-1:0] col_full;
      logic [1:0] col;
      col_full = cnt_ff - AXIS_CNT;
      col      = col_full[1:0];
      if (cnt_ff < AXIS_CNT) begin
         kind_in  = dhfk_pkg::KIND_JOINT;
         index_in = cnt_ff[2:0];
         for (int i = 0; i < 3; i++) begin
            coord_in[i] = dhfk_pkg::saturate(dhfk_pkg::round_away(
               dhfk_pkg::SUM_W'(pos_bank_ff[cnt_ff[2:0]][i]), dhfk_pkg::GUARD_BITS));
         end
      end else begin
         kind_in  = dhfk_pkg::KIND_AXIS;
         index_in = {1'b0, col};
         for (int i = 0; i < 3; i++) begin
            coord_in[i] = dhfk_pkg::saturate(dhfk_pkg::round_away(
               dhfk_pkg::SUM_W'(rot_bank_ff[i][col]), dhfk_pkg::Q_BITS - FRACTION_BITS));
         end
      end
   end

   // item counter
   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      if (in_valid) begin
         active_in = 1'b1;
         cnt_in    = '0;
      end else if (active_ff) begin
         if (cnt_ff == LAST_CNT) begin
            active_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         active_ff    <= active_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= active_ff;
         last_ff      <= active_ff && (cnt_ff == LAST_CNT);
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      index_ff <= index_in;
      coord_ff <= coord_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item_kind  = kind_ff;
   assign rsp_item_index = index_ff;
   assign rsp_coord_x    = $signed(coord_ff[0]);
   assign rsp_coord_y    = $signed(coord_ff[1]);
   assign rsp_coord_z    = $signed(coord_ff[2]);
   assign rsp_last_item  = last_ff;

`ifndef ASSERT_OFF
   // a new pose never lands on the bank while an earlier one is mid-way
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> (!active_ff || cnt_ff == LAST_CNT))
      else $error("pose bank reloaded while items still pending");

   // the tenth item carries the last flag
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (active_ff && cnt_ff == LAST_CNT) |=> (rsp_valid_ff && last_ff))
      else $error("last item not flagged");
`endif

endmodule

FILE: design/dh_forward_kinematics_6dof_core.sv
// top level of the six-axis dh forward kinematics core
`timescale 1ns / 1ps
// Usage:
//   An item (six joint angles on req_joint_angle_1..6) is taken at a rising edge
//   where start is high and busy is low. busy is raised after each accepted item
//   and held while the spacing counter counts down, so no pose reloads the
//   result bank while items of the previous one are pending. Each pose yields
//   ten results on the rsp_ ports, one per cycle, marked by rsp_valid: joint
//   positions 0..6, then tool x, y and z axes; rsp_last_item flags the tenth.
//   A pose passes the entry register, the 8-stage sine pipeline, one translation
//   stage, two stages for each of the six dh transforms, the result bank and the
//   output register. Several poses are in flight at once; results are never held
//   back, as the receiver takes every item in the cycle it is shown. Link
//   lengths and offsets are written on the csr_ port (write enable, index, data)
//   by the user only while no pose is in flight; the block does not enforce it.
//   Unknown indexes are ignored. Synchronous reset clears the pipeline valid
//   bits, busy and the output strobe, and loads the default link geometry.
module dh_forward_kinematics_6dof_core #(
   parameter int FRACTION_BITS = dhfk_pkg::FRACTION_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [dhfk_pkg::ANGLE_W-1:0]   req_joint_angle_1,
   input  logic signed [dhfk_pkg::ANGLE_W-1:0]   req_joint_angle_2,
   input  logic signed [dhfk_pkg::ANGLE_W-1:0]   req_joint_angle_3,
   input  logic signed [dhfk_pkg::ANGLE_W-1:0]   req_joint_angle_4,
   input  logic signed [dhfk_pkg::ANGLE_W-1:0]   req_joint_angle_5,
   input  logic signed [dhfk_pkg::ANGLE_W-1:0]   req_joint_angle_6,
   output logic                                  rsp_valid,
   output logic                                  rsp_item_kind,
   output logic [2:0]                            rsp_item_index,
   output logic signed [dhfk_pkg::COORD_W-1:0]   rsp_coord_x,
   output logic signed [dhfk_pkg::COORD_W-1:0]   rsp_coord_y,
   output logic signed [dhfk_pkg::COORD_W-1:0]   rsp_coord_z,
   output logic                                  rsp_last_item,
   input  logic                                  csr_write_en,
   input  logic [dhfk_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dhfk_pkg::LEN_W-1:0]            csr_wdata
);

   localparam int NJ = dhfk_pkg::JOINT_COUNT;

   logic                                accept;
   logic [dhfk_pkg::CNT_W-1:0]          gap_ff, gap_in;

   logic signed [dhfk_pkg::LEN_W-1:0]   first_link_ff, second_link_ff;
   logic signed [dhfk_pkg::LEN_W-1:0]   base_height_ff, forearm_ff, flange_ff;

   logic [dhfk_pkg::ANGLE_W-1:0]        th_in [0:NJ-1];
   logic [dhfk_pkg::ANGLE_W-1:0]        th_ff [0:NJ-1];
   logic [dhfk_pkg::ANGLE_W-1:0]        thc   [0:NJ-1];
   logic                                v0_ff;
   logic                                sv_ff [1:dhfk_pkg::SINE_LATENCY];
   logic signed [dhfk_pkg::TRIG_W-1:0]  sin_w [0:NJ-1];
   logic signed [dhfk_pkg::TRIG_W-1:0]  cos_w [0:NJ-1];

   logic                                vt_ff;
   logic signed [dhfk_pkg::LEN_W-1:0]   la [0:NJ-1];
   logic signed [dhfk_pkg::LEN_W-1:0]   ld [0:NJ-1];
   logic signed [dhfk_pkg::TRIG_W-1:0]  t0_in [0:NJ-1];
   logic signed [dhfk_pkg::TRIG_W-1:0]  t1_in [0:NJ-1];
   logic signed [dhfk_pkg::TRIG_W-1:0]  ct_ff [0:NJ-1];
   logic signed [dhfk_pkg::TRIG_W-1:0]  st_ff [0:NJ-1];
   logic signed [dhfk_pkg::TRIG_W-1:0]  t0_ff [0:NJ-1];
   logic signed [dhfk_pkg::TRIG_W-1:0]  t1_ff [0:NJ-1];

   logic                                valid_c [0:NJ];
   logic signed [dhfk_pkg::TRIG_W-1:0]  ct_c  [0:NJ][0:NJ-1];
   logic signed [dhfk_pkg::TRIG_W-1:0]  st_c  [0:NJ][0:NJ-1];
   logic signed [dhfk_pkg::TRIG_W-1:0]  t0_c  [0:NJ][0:NJ-1];
   logic signed [dhfk_pkg::TRIG_W-1:0]  t1_c  [0:NJ][0:NJ-1];
   logic signed [dhfk_pkg::TRIG_W-1:0]  rot_c [0:NJ][0:2][0:2];
   logic signed [dhfk_pkg::POS_W-1:0]   pos_c [0:NJ][0:NJ][0:2];

   // accept and spacing of poses
   assign accept = start && !busy;
   assign busy   = (gap_ff != '0);

   always_comb begin
      gap_in = gap_ff;
      if (accept) begin
         gap_in = dhfk_pkg::CNT_W'(dhfk_pkg::ITEM_COUNT - 1);
      end else if (gap_ff != '0) begin
         gap_in = gap_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
      end else begin
         gap_ff <= gap_in;
      end
   end

   // link geometry registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_link_ff  <= 18'sd4588;
         second_link_ff <= 18'sd23593;
         base_height_ff <= 18'sd23069;
         forearm_ff     <= 18'sd24904;
         flange_ff      <= 18'sd4260;
      end else if (csr_write_en) begin
         unique case (csr_index)
            dhfk_pkg::CSR_FIRST_LINK:  first_link_ff  <= $signed(csr_wdata);
            dhfk_pkg::CSR_SECOND_LINK: second_link_ff <= $signed(csr_wdata);
            dhfk_pkg::CSR_BASE_HEIGHT: base_height_ff <= $signed(csr_wdata);
            dhfk_pkg::CSR_FOREARM:     forearm_ff     <= $signed(csr_wdata);
            dhfk_pkg::CSR_FLANGE:      flange_ff      <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // joint angles to dh angles, wrapping modulo one turn
   always_comb begin
      th_in[0] = req_joint_angle_1;
      th_in[1] = req_joint_angle_2 - dhfk_pkg::QUARTER_TURN;
      th_in[2] = req_joint_angle_3 + dhfk_pkg::HALF_TURN - req_joint_angle_2;
      th_in[3] = req_joint_angle_4;
      th_in[4] = dhfk_pkg::HALF_TURN - req_joint_angle_5;
      th_in[5] = req_joint_angle_6 + dhfk_pkg::HALF_TURN;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         th_ff <= th_in;
      end
   end

   // sine and cosine units
   for (genvar k = 0; k < NJ; k++) begin : g_trig
      assign thc[k] = th_ff[k] + dhfk_pkg::QUARTER_TURN;
      dhfk_sine u_sin (.clock(clock), .angle(th_ff[k]), .sine(sin_w[k]));
      dhfk_sine u_cos (.clock(clock), .angle(thc[k]),   .sine(cos_w[k]));
   end

   // valid bits along the entry, sine and translation stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         vt_ff <= 1'b0;
         for (int s = 1; s <= dhfk_pkg::SINE_LATENCY; s++) begin
            sv_ff[s] <= 1'b0;
         end
      end else begin
         v0_ff    <= accept;
         sv_ff[1] <= v0_ff;
         for (int s = 2; s <= dhfk_pkg::SINE_LATENCY; s++) begin
            sv_ff[s] <= sv_ff[s-1];
         end
         vt_ff <= sv_ff[dhfk_pkg::SINE_LATENCY];
      end
   end

   // per-joint link lengths and offsets
   always_comb begin
      for (int k = 0; k < NJ; k++) begin
         la[k] = '0;
         ld[k] = '0;
      end
      la[0] = first_link_ff;
      la[1] = second_link_ff;
      ld[0] = base_height_ff;
      ld[3] = forearm_ff;
      ld[5] = flange_ff;
   end

   // translation along the link: a times cos and sin, guard bits kept
   always_comb begin
      logic signed [dhfk_pkg::DPROD_W-1:0] pc;
      logic signed [dhfk_pkg::DPROD_W-1:0] ps;
      logic signed [dhfk_pkg::SUM_W-1:0]   rc;
      logic signed [dhfk_pkg::SUM_W-1:0]   rs;
      for (int k = 0; k < NJ; k++) begin
         pc = la[k] * cos_w[k];
         ps = la[k] * sin_w[k];
         rc = dhfk_pkg::round_away(dhfk_pkg::SUM_W'(pc), dhfk_pkg::Q_BITS - dhfk_pkg::GUARD_BITS);
         rs = dhfk_pkg::round_away(dhfk_pkg::SUM_W'(ps), dhfk_pkg::Q_BITS - dhfk_pkg::GUARD_BITS);
         t0_in[k] = rc[dhfk_pkg::TRIG_W-1:0];
         t1_in[k] = rs[dhfk_pkg::TRIG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      ct_ff <= cos_w;
      st_ff <= sin_w;
      t0_ff <= t0_in;
      t1_ff <= t1_in;
   end

   // head of the transform chain: identity rotation at the origin
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int c = 0; c < 3; c++) begin
            rot_c[0][i][c] = (i == c) ? dhfk_pkg::ONE_Q30 : '0;
         end
         for (int p = 0; p <= NJ; p++) begin
            pos_c[0][p][i] = '0;
         end
      end
   end

   assign valid_c[0] = vt_ff;
   assign ct_c[0]    = ct_ff;
   assign st_c[0]    = st_ff;
   assign t0_c[0]    = t0_ff;
   assign t1_c[0]    = t1_ff;

   // six dh transform stages
   for (genvar k = 0; k < NJ; k++) begin : g_joint
      dhfk_joint #(.JOINT_INDEX(k)) u_joint (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (valid_c[k]),
         .link_offset (ld[k]),
         .ct_in       (ct_c[k]),
         .st_in       (st_c[k]),
         .t0_in       (t0_c[k]),
         .t1_in       (t1_c[k]),
         .rot_in      (rot_c[k]),
         .pos_in      (pos_c[k]),
         .out_valid   (valid_c[k+1]),
         .ct_out      (ct_c[k+1]),
         .st_out      (st_c[k+1]),
         .t0_out      (t0_c[k+1]),
         .t1_out      (t1_c[k+1]),
         .rot_out     (rot_c[k+1]),
         .pos_out     (pos_c[k+1])
      );
   end

   // result serializer
   dhfk_out #(.FRACTION_BITS(FRACTION_BITS)) u_out (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (valid_c[NJ]),
      .pos_in         (pos_c[NJ]),
      .rot_in         (rot_c[NJ]),
      .rsp_valid      (rsp_valid),
      .rsp_item_kind  (rsp_item_kind),
      .rsp_item_index (rsp_item_index),
      .rsp_coord_x    (rsp_coord_x),
      .rsp_coord_y    (rsp_coord_y),
      .rsp_coord_z    (rsp_coord_z),
      .rsp_last_item  (rsp_last_item)
   );

`ifndef ASSERT_OFF
   // an accepted item always opens the busy window
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accept");

   // the last item of a pose is the z axis
   a_last_is_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_last_item |-> (rsp_valid && rsp_item_kind == dhfk_pkg::KIND_AXIS))
      else $error("last item is not a tool axis");
`endif

endmodule
